/* sv/dki_pkg.sv */
// Package for the delta kernel interpolator: fixed-point widths, constants,
// datapath command codes and the controller/datapath link types.
// No dependencies.
package dki_pkg;

    localparam int FRAC_BITS = 16;

    localparam int IN_W   = 32;
    localparam int SUM_W  = 48;
    localparam int MAG_W  = IN_W + 1;
    localparam int INV_W  = 32;
    localparam int SCL_W  = MAG_W + INV_W;
    localparam int R_W    = FRAC_BITS + 2;
    localparam int R2_W   = FRAC_BITS + 4;
    localparam int R3_W   = FRAC_BITS + 5;
    localparam int K_W    = FRAC_BITS + 1;
    localparam int KS_W   = FRAC_BITS + 12;
    localparam int S_W    = FRAC_BITS + 4;
    localparam int SQ_W   = 2 * FRAC_BITS + 4;
    localparam int X3_W   = FRAC_BITS + 3;
    localparam int Q3_W   = FRAC_BITS + 2;
    localparam int TP_W   = IN_W + K_W + 1;
    localparam int TERM_W = TP_W - FRAC_BITS;

    localparam int ONE_FX         = 1 << FRAC_BITS;
    localparam int HALF_FX        = 1 << (FRAC_BITS - 1);
    localparam int R_MAX_FX       = 3 << FRAC_BITS;
    localparam int TWO_THIRDS_FX  = ((2 << FRAC_BITS) + 1) / 3;
    localparam int FOUR_THIRDS_FX = ((4 << FRAC_BITS) + 1) / 3;
    localparam int D3_SH          = FRAC_BITS + 4;
    localparam int D3_MUL         = ((1 << D3_SH) + 2) / 3;

    localparam int SQRT_CYCLES = (FRAC_BITS + 3) / 2;
    localparam int SQC_W       = $clog2(SQRT_CYCLES);

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [1:0] KSEL_ZERO  = 2'd0;
    localparam logic [1:0] KSEL_CUBIC = 2'd1;
    localparam logic [1:0] KSEL_FOUR  = 2'd2;
    localparam logic [1:0] KSEL_HAT   = 2'd3;

    localparam logic REG_KERNEL_SELECT   = 1'b0;
    localparam logic REG_INVERSE_SPACING = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_SCALE,
        OP_SQUARE,
        OP_CUBE,
        OP_DIV3,
        OP_SQRT,
        OP_KERNEL,
        OP_PROD,
        OP_TERM,
        OP_ACC,
        OP_EMIT
    } dki_op_t;

    typedef struct packed {
        dki_op_t op;
        logic    axis;
    } dki_cmd_t;

    typedef struct packed {
        logic last;
    } dki_status_t;

endpackage

/* sv/dki_channels.sv */
// Handshake channels of the delta kernel interpolator: node items in,
// interpolated results out. Depends on dki_pkg.
interface dki_node_if;
    logic                              valid;
    logic                              ready;
    logic signed [dki_pkg::IN_W-1:0]   node_x;
    logic signed [dki_pkg::IN_W-1:0]   node_y;
    logic signed [dki_pkg::IN_W-1:0]   node_value;
    logic signed [dki_pkg::IN_W-1:0]   query_x;
    logic signed [dki_pkg::IN_W-1:0]   query_y;
    logic                              last_node;

    modport source (output valid, node_x, node_y, node_value, query_x, query_y,
                    last_node, input ready);
    modport sink   (input valid, node_x, node_y, node_value, query_x, query_y,
                    last_node, output ready);
endinterface

interface dki_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [dki_pkg::SUM_W-1:0]  interp_value;

    modport source (output valid, interp_value, input ready);
    modport sink   (input valid, interp_value, output ready);
endinterface

/* sv/dki_ctrl.sv */
// Controller of the delta kernel interpolator: sequences the per-axis kernel
// steps, the product, accumulation and result handshake. Depends on dki_pkg.
module dki_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  dki_pkg::dki_status_t status,
    output dki_pkg::dki_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SCALE,
        ST_SQUARE,
        ST_CUBE,
        ST_DIV3,
        ST_SQRT,
        ST_KERNEL,
        ST_PROD,
        ST_TERM,
        ST_ACC
    } state_t;

    state_t                    state_reg, state_next;
    logic                      axis_reg, axis_next;
    logic [dki_pkg::SQC_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = dki_pkg::OP_NONE;
        cmd.axis       = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = dki_pkg::OP_LOAD;
                    axis_next  = 1'b0;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.op     = dki_pkg::OP_DIFF;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.op     = dki_pkg::OP_SCALE;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cmd.op     = dki_pkg::OP_SQUARE;
                state_next = ST_CUBE;
            end
            ST_CUBE:
            begin
                cmd.op     = dki_pkg::OP_CUBE;
                state_next = ST_DIV3;
            end
            ST_DIV3:
            begin
                cmd.op     = dki_pkg::OP_DIV3;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op   = dki_pkg::OP_SQRT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == dki_pkg::SQC_W'(dki_pkg::SQRT_CYCLES - 1))
                begin
                    state_next = ST_KERNEL;
                end
            end
            ST_KERNEL:
            begin
                cmd.op = dki_pkg::OP_KERNEL;
                if (axis_reg)
                begin
                    state_next = ST_PROD;
                end
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_PROD:
            begin
                cmd.op     = dki_pkg::OP_PROD;
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                cmd.op     = dki_pkg::OP_TERM;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!status.last)
                begin
                    cmd.op     = dki_pkg::OP_ACC;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = dki_pkg::OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* sv/dki_datapath.sv */
// Datapath of the delta kernel interpolator: configuration registers,
// distance scaling, kernel evaluation, square root, product and accumulator.
// Depends on dki_pkg.
module dki_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dki_pkg::dki_cmd_t                  cmd,
    output dki_pkg::dki_status_t               status,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [dki_pkg::INV_W-1:0]          cfg_data,
    input  logic signed [dki_pkg::IN_W-1:0]    node_x,
    input  logic signed [dki_pkg::IN_W-1:0]    node_y,
    input  logic signed [dki_pkg::IN_W-1:0]    node_value,
    input  logic signed [dki_pkg::IN_W-1:0]    query_x,
    input  logic signed [dki_pkg::IN_W-1:0]    query_y,
    input  logic                               last_node,
    output logic signed [dki_pkg::SUM_W-1:0]   interp_value
);

    localparam int F    = dki_pkg::FRAC_BITS;
    localparam int KS_W = dki_pkg::KS_W;

    logic [1:0]                        ksel_reg;
    logic [dki_pkg::INV_W-1:0]         inv_reg;
    logic signed [dki_pkg::SUM_W-1:0]  sum_reg;

    logic signed [dki_pkg::IN_W-1:0]   nx_reg, ny_reg, val_reg, qx_reg, qy_reg;
    logic                              last_reg;
    logic [dki_pkg::MAG_W-1:0]         mag_reg;
    logic [dki_pkg::R_W-1:0]           r_reg;
    logic [dki_pkg::R2_W-1:0]          r2_reg;
    logic [dki_pkg::R3_W-1:0]          r3_reg;
    logic [dki_pkg::S_W-1:0]           s_reg;
    logic [dki_pkg::Q3_W-1:0]          q3_reg;
    logic [dki_pkg::SQ_W-1:0]          sqv_reg, sqr_reg, sqb_reg;
    logic [dki_pkg::K_W-1:0]           kx_reg, ky_reg, p_reg;
    logic signed [dki_pkg::TERM_W-1:0] term_reg;
    logic signed [dki_pkg::SUM_W-1:0]  out_reg;

    logic signed [dki_pkg::MAG_W-1:0]  diff;
    logic signed [dki_pkg::IN_W-1:0]   cur_node, cur_query;
    logic [dki_pkg::SCL_W-1:0]         scl_prod;
    logic [dki_pkg::SCL_W-F-1:0]       scl_hi;
    logic [dki_pkg::R_W-1:0]           r_next;
    logic [2*dki_pkg::R_W-1:0]         sq_prod;
    logic [dki_pkg::R2_W+dki_pkg::R_W-1:0] cu_prod;
    logic signed [KS_W-1:0]            rs, r2s, r3s, q3s, sqs, s_calc, k_calc;
    logic [dki_pkg::X3_W-1:0]          x3;
    logic [2*dki_pkg::X3_W-1:0]        d3_prod;
    logic [dki_pkg::SQ_W-1:0]          v_it, res_it, bit_it;
    logic [dki_pkg::K_W-1:0]           k_clamped;
    logic [2*dki_pkg::K_W-1:0]         p_prod;
    logic signed [dki_pkg::TP_W-1:0]   t_prod;
    logic signed [dki_pkg::SUM_W:0]    acc_sum;
    logic signed [dki_pkg::SUM_W-1:0]  acc_sat;

    always_comb
    begin
        cur_node  = cmd.axis ? ny_reg : nx_reg;
        cur_query = cmd.axis ? qy_reg : qx_reg;
        diff      = {cur_node[dki_pkg::IN_W-1], cur_node}
                  - {cur_query[dki_pkg::IN_W-1], cur_query};
    end

    always_comb
    begin
        scl_prod = dki_pkg::SCL_W'(mag_reg) * dki_pkg::SCL_W'(inv_reg);
        scl_hi   = scl_prod[dki_pkg::SCL_W-1:F];
        if (scl_hi > (dki_pkg::SCL_W-F)'(dki_pkg::R_MAX_FX))
        begin
            r_next = dki_pkg::R_W'(dki_pkg::R_MAX_FX);
        end
        else
        begin
            r_next = scl_hi[dki_pkg::R_W-1:0];
        end
        sq_prod = (2*dki_pkg::R_W)'(r_reg) * (2*dki_pkg::R_W)'(r_reg);
        cu_prod = (dki_pkg::R2_W+dki_pkg::R_W)'(r2_reg)
                * (dki_pkg::R2_W+dki_pkg::R_W)'(r_reg);
    end

    always_comb
    begin
        rs  = KS_W'(r_reg);
        r2s = KS_W'(r2_reg);
        r3s = KS_W'(r3_reg);
        q3s = KS_W'(q3_reg);
        sqs = KS_W'(sqr_reg[F+1:0]);
        if (r_reg < dki_pkg::R_W'(dki_pkg::ONE_FX))
        begin
            s_calc = KS_W'(dki_pkg::ONE_FX) + (rs <<< 2) - (r2s <<< 2);
        end
        else
        begin
            s_calc = (rs <<< 3) + (rs <<< 2) - KS_W'(7 * dki_pkg::ONE_FX) - (r2s <<< 2);
        end
        x3      = {r3_reg[F:0], 2'b00};
        d3_prod = (2*dki_pkg::X3_W)'(x3) * (2*dki_pkg::X3_W)'(dki_pkg::D3_MUL);
    end

    always_comb
    begin
        v_it   = sqv_reg;
        res_it = sqr_reg;
        bit_it = sqb_reg;
        for (int i = 0; i < 2; i++)
        begin
            if (bit_it != '0)
            begin
                if (v_it >= res_it + bit_it)
                begin
                    v_it   = v_it - (res_it + bit_it);
                    res_it = (res_it >> 1) + bit_it;
                end
                else
                begin
                    res_it = res_it >> 1;
                end
                bit_it = bit_it >> 2;
            end
        end
    end

    always_comb
    begin
        k_calc = '0;
        case (ksel_reg)
            dki_pkg::KSEL_CUBIC:
            begin
                if (r_reg <= dki_pkg::R_W'(dki_pkg::HALF_FX))
                begin
                    k_calc = KS_W'(dki_pkg::TWO_THIRDS_FX) - (r2s <<< 2) + (r3s <<< 2);
                end
                else if (r_reg <= dki_pkg::R_W'(dki_pkg::ONE_FX))
                begin
                    k_calc = KS_W'(dki_pkg::FOUR_THIRDS_FX) - (rs <<< 2)
                           + (r2s <<< 2) - q3s;
                end
            end
            dki_pkg::KSEL_FOUR:
            begin
                if (r_reg < dki_pkg::R_W'(dki_pkg::ONE_FX))
                begin
                    k_calc = (KS_W'(3 * dki_pkg::ONE_FX) - (rs <<< 1) + sqs) >>> 3;
                end
                else if (r_reg <= dki_pkg::R_W'(2 * dki_pkg::ONE_FX))
                begin
                    k_calc = (KS_W'(5 * dki_pkg::ONE_FX) - (rs <<< 1) - sqs) >>> 3;
                end
            end
            dki_pkg::KSEL_HAT:
            begin
                if (r_reg <= dki_pkg::R_W'(dki_pkg::ONE_FX))
                begin
                    k_calc = KS_W'(dki_pkg::ONE_FX) - rs;
                end
            end
            default:
            begin
                k_calc = '0;
            end
        endcase
        if (k_calc[KS_W-1])
        begin
            k_clamped = '0;
        end
        else if (k_calc > KS_W'(dki_pkg::ONE_FX))
        begin
            k_clamped = dki_pkg::K_W'(dki_pkg::ONE_FX);
        end
        else
        begin
            k_clamped = k_calc[dki_pkg::K_W-1:0];
        end
    end

    always_comb
    begin
        p_prod  = (2*dki_pkg::K_W)'(kx_reg) * (2*dki_pkg::K_W)'(ky_reg);
        t_prod  = dki_pkg::TP_W'(val_reg) * dki_pkg::TP_W'(signed'({1'b0, p_reg}));
        acc_sum = {sum_reg[dki_pkg::SUM_W-1], sum_reg}
                + (dki_pkg::SUM_W+1)'(term_reg);
        if (acc_sum[dki_pkg::SUM_W] != acc_sum[dki_pkg::SUM_W-1])
        begin
            acc_sat = acc_sum[dki_pkg::SUM_W] ? dki_pkg::SUM_MIN : dki_pkg::SUM_MAX;
        end
        else
        begin
            acc_sat = acc_sum[dki_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksel_reg <= dki_pkg::KSEL_FOUR;
            inv_reg  <= dki_pkg::INV_W'(dki_pkg::ONE_FX);
            sum_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dki_pkg::REG_KERNEL_SELECT:   ksel_reg <= cfg_data[1:0];
                    dki_pkg::REG_INVERSE_SPACING: inv_reg  <= cfg_data;
                    default:                      ksel_reg <= ksel_reg;
                endcase
            end
            if (cmd.op == dki_pkg::OP_ACC)
            begin
                sum_reg <= acc_sat;
            end
            else if (cmd.op == dki_pkg::OP_EMIT)
            begin
                sum_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            dki_pkg::OP_LOAD:
            begin
                nx_reg   <= node_x;
                ny_reg   <= node_y;
                val_reg  <= node_value;
                qx_reg   <= query_x;
                qy_reg   <= query_y;
                last_reg <= last_node;
            end
            dki_pkg::OP_DIFF:
            begin
                mag_reg <= diff[dki_pkg::MAG_W-1] ? dki_pkg::MAG_W'(-diff)
                                                  : dki_pkg::MAG_W'(diff);
            end
            dki_pkg::OP_SCALE:
            begin
                r_reg <= r_next;
            end
            dki_pkg::OP_SQUARE:
            begin
                r2_reg <= sq_prod[F+dki_pkg::R2_W-1:F];
            end
            dki_pkg::OP_CUBE:
            begin
                r3_reg <= cu_prod[F+dki_pkg::R3_W-1:F];
                s_reg  <= s_calc[KS_W-1] ? '0 : s_calc[dki_pkg::S_W-1:0];
            end
            dki_pkg::OP_DIV3:
            begin
                q3_reg  <= d3_prod[dki_pkg::D3_SH+dki_pkg::Q3_W-1:dki_pkg::D3_SH];
                sqv_reg <= {s_reg, {F{1'b0}}};
                sqr_reg <= '0;
                sqb_reg <= {2'b01, {(dki_pkg::SQ_W-2){1'b0}}};
            end
            dki_pkg::OP_SQRT:
            begin
                sqv_reg <= v_it;
                sqr_reg <= res_it;
                sqb_reg <= bit_it;
            end
            dki_pkg::OP_KERNEL:
            begin
                if (cmd.axis)
                begin
                    ky_reg <= k_clamped;
                end
                else
                begin
                    kx_reg <= k_clamped;
                end
            end
            dki_pkg::OP_PROD:
            begin
                p_reg <= p_prod[F+dki_pkg::K_W-1:F];
            end
            dki_pkg::OP_TERM:
            begin
                term_reg <= t_prod[dki_pkg::TP_W-1:F];
            end
            dki_pkg::OP_EMIT:
            begin
                out_reg <= acc_sat;
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

    assign status.last  = last_reg;
    assign interp_value = out_reg;

endmodule

/* sv/delta_kernel_interpolator.sv */
// Delta kernel interpolator top level: one node item at a time, no new item
// until it is done. Each axis runs the shared kernel datapath: difference,
// scale, square, cube, divide by 3, 2-bit-per-cycle square root and kernel.
// A result waits in an output register while the next item is taken.
// Reset clears the controller, the running sum and sets kernel_select to the
// four-point kernel and inverse_spacing to 1.0. Depends on dki_pkg, dki_channels.
module delta_kernel_interpolator (
    input  logic                       clk,
    input  logic                       rst_n,
    dki_node_if.sink                   node_in,
    dki_result_if.source               result_out,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [dki_pkg::INV_W-1:0]  cfg_data
);

    dki_pkg::dki_cmd_t    cmd;
    dki_pkg::dki_status_t status;

    dki_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (node_in.valid),
        .in_ready  (node_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dki_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .node_x       (node_in.node_x),
        .node_y       (node_in.node_y),
        .node_value   (node_in.node_value),
        .query_x      (node_in.query_x),
        .query_y      (node_in.query_y),
        .last_node    (node_in.last_node),
        .interp_value (result_out.interp_value)
    );

endmodule

/* sv/dki_checker.sv */
// Port-level checks for the delta kernel interpolator, bound to the top level.
// Depends on dki_pkg.
module dki_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [dki_pkg::SUM_W-1:0]  interp_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(interp_value))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised while idle");

endmodule

bind delta_kernel_interpolator dki_checker u_dki_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (node_in.valid),
    .in_ready     (node_in.ready),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .interp_value (result_out.interp_value)
);

/* verif/dki_tb_channels.sv */
// Testbench-side note: the channel interfaces come from the RTL file
// sv/dki_channels.sv; this file holds the scoreboard class. Depends on dki_pkg.
package dki_tb_pkg;
    import dki_pkg::*;

    class interp_scoreboard;
        logic [1:0]  kernel_sel;
        logic [31:0] inv_spacing;
        longint      running_sum;
        longint      expected_sums[$];
        int          errors;

        function new();
            kernel_sel  = KSEL_FOUR;
            inv_spacing = 32'h0001_0000;
            running_sum = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == REG_KERNEL_SELECT)
                kernel_sel = data[1:0];
            else
                inv_spacing = data;
        endfunction

        function longint fdiv(longint v, int s);
            return v >>> s;
        endfunction

        function longint isqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return longint'(res);
        endfunction

        function longint kernel_weight(logic signed [31:0] node, logic signed [31:0] query);
            longint d;
            longint r;
            longint r2;
            longint r3;
            longint s;
            longint k;
            longint unsigned scaled;
            d = longint'(node) - longint'(query);
            if (d < 0)
                d = -d;
            scaled = (longint'(d) * longint'({32'd0, inv_spacing})) >> FRAC_BITS;
            if (scaled > 3 * ONE_FX)
                scaled = 3 * ONE_FX;
            r = longint'(scaled);
            r2 = (r * r) >>> FRAC_BITS;
            r3 = (r2 * r) >>> FRAC_BITS;
            k = 0;
            case (kernel_sel)
                KSEL_CUBIC:
                    if (r <= HALF_FX)
                        k = TWO_THIRDS_FX - 4 * r2 + 4 * r3;
                    else if (r <= ONE_FX)
                        k = FOUR_THIRDS_FX - 4 * r + 4 * r2 - (4 * r3) / 3;
                KSEL_FOUR:
                    if (r < ONE_FX)
                    begin
                        s = ONE_FX + 4 * r - 4 * r2;
                        if (s < 0)
                            s = 0;
                        k = fdiv(3 * ONE_FX - 2 * r + isqrt(s << FRAC_BITS), 3);
                    end
                    else if (r <= 2 * ONE_FX)
                    begin
                        s = 12 * r - 7 * ONE_FX - 4 * r2;
                        if (s < 0)
                            s = 0;
                        k = fdiv(5 * ONE_FX - 2 * r - isqrt(s << FRAC_BITS), 3);
                    end
                KSEL_HAT:
                    if (r <= ONE_FX)
                        k = ONE_FX - r;
                default:
                    k = 0;
            endcase
            if (k < 0)
                k = 0;
            if (k > ONE_FX)
                k = ONE_FX;
            return k;
        endfunction

        function void note_node(logic signed [31:0] nx, logic signed [31:0] ny,
                                logic signed [31:0] nv, logic signed [31:0] qx,
                                logic signed [31:0] qy, logic last);
            longint kx;
            longint ky;
            longint p;
            longint sum;
            kx = kernel_weight(nx, qx);
            ky = kernel_weight(ny, qy);
            p = (kx * ky) >>> FRAC_BITS;
            sum = running_sum + ((longint'(nv) * p) >>> FRAC_BITS);
            if (sum > 64'sh7FFF_FFFF_FFFF)
                sum = 64'sh7FFF_FFFF_FFFF;
            if (sum < -64'sh8000_0000_0000)
                sum = -64'sh8000_0000_0000;
            if (last)
            begin
                expected_sums.push_back(sum);
                running_sum = 0;
            end
            else
                running_sum = sum;
        endfunction

        task report(string msg);
            $display("%s", msg);
            errors++;
        endtask

        task check_result(logic signed [47:0] got);
            longint want;
            if (expected_sums.size() == 0)
            begin
                report($sformatf("unexpected result %0d", got));
                return;
            end
            want = expected_sums.pop_front();
            if (longint'(got) != want)
                report($sformatf("interp_value %0d, wanted %0d", got, want));
        endtask
    endclass
endpackage

/* verif/testbench.sv */
// Testbench for delta_kernel_interpolator: random and directed node items,
// scoreboard prediction of every sum. Depends on dki_pkg, dki_channels, dki_tb_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dki_pkg::*;
    import dki_tb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        no_idle = 1'b0;
    longint      cycles = 0;
    interp_scoreboard sb;

    dki_node_if   node_in ();
    dki_result_if result_out ();

    delta_kernel_interpolator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .node_in    (node_in.sink),
        .result_out (result_out.source),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        node_in.valid = 1'b0;
        node_in.node_x = '0;
        node_in.node_y = '0;
        node_in.node_value = '0;
        node_in.query_x = '0;
        node_in.query_y = '0;
        node_in.last_node = 1'b0;
        result_out.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd4_000_000)
        begin
            $display("delta_kernel_interpolator: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_out.valid && result_out.ready)
            sb.check_result(result_out.interp_value);
        result_out.ready <= no_idle || ($urandom_range(99) >= 31);
    end

    task automatic write_reg(logic idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic send_node(logic [31:0] nx, logic [31:0] ny, logic [31:0] nv,
                             logic [31:0] qx, logic [31:0] qy, logic last);
        while (!no_idle && $urandom_range(99) < 31)
        begin
            node_in.valid <= 1'b0;
            @(posedge clk);
        end
        node_in.valid      <= 1'b1;
        node_in.node_x     <= nx;
        node_in.node_y     <= ny;
        node_in.node_value <= nv;
        node_in.query_x    <= qx;
        node_in.query_y    <= qy;
        node_in.last_node  <= last;
        do
            @(posedge clk);
        while (!node_in.ready);
        sb.note_node(nx, ny, nv, qx, qy, last);
    endtask

    task automatic drain();
        node_in.valid <= 1'b0;
        while (sb.expected_sums.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
    endtask

    // near offsets land inside the kernel support; far ones stress the clamp
    function automatic logic [31:0] offset(logic [31:0] q);
        case ($urandom_range(9))
            0: return $urandom;
            1: return q + $urandom_range(3 << 16) - ($urandom_range(3 << 16));
            default: return q + $urandom_range(2 << 16) - $urandom_range(2 << 16);
        endcase
    endfunction

    task automatic random_query(int nodes);
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] v;
        qx = $urandom;
        qy = $urandom;
        for (int i = 0; i < nodes; i++)
        begin
            v = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1 << 20) - (1 << 19);
            send_node(offset(qx), offset(qy), v, qx, qy, i == nodes - 1);
        end
    endtask

    initial
    begin
        logic [31:0] spacing [5];
        int sent;
        int nodes;
        sb = new();
        spacing = '{32'd1, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'hFFFF_FFFF};
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings first
        send_node(32'h0000_8000, 32'h0000_0000, 32'h0001_0000, 0, 0, 1'b0);
        send_node(32'h0001_8000, 32'hFFFF_4000, 32'h7FFF_FFFF, 0, 0, 1'b1);
        drain();
        for (int ks = 0; ks < 4; ks++)
        begin
            write_reg(REG_KERNEL_SELECT, ks);
            send_node(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 1'b1);
            send_node(32'h0000_4000, 32'h0000_C000, 32'h8000_0000, 0, 0, 1'b0);
            send_node(32'h0000_8000, 32'h0001_0000, 32'hFFFF_FFFF, 0, 0, 1'b0);
            send_node(0, 0, 32'h7FFF_FFFF, 0, 0, 1'b1);
            drain();
        end
        // accumulate full-scale positive, then full-scale negative node values
        write_reg(REG_KERNEL_SELECT, KSEL_HAT);
        for (int i = 0; i < 70000 / 1000; i++)
            send_node(0, 0, 32'h7FFF_FFFF, 0, 0, 1'b0);
        send_node(0, 0, 32'h7FFF_FFFF, 0, 0, 1'b1);
        for (int i = 0; i < 70; i++)
            send_node(0, 0, 32'h8000_0000, 0, 0, 1'b0);
        send_node(0, 0, 32'h8000_0000, 0, 0, 1'b1);
        drain();

        sent = 0;
        for (int phase = 0; phase < 12; phase++)
        begin
            write_reg(REG_KERNEL_SELECT, phase % 4);
            write_reg(REG_INVERSE_SPACING, (phase == 11) ? $urandom : spacing[phase % 5]);
            no_idle = (phase == 5);
            while (sent < (phase + 1) * 150)
            begin
                nodes = $urandom_range(1, 16);
                random_query(nodes);
                sent = sent + nodes;
            end
            drain();
        end
        no_idle = 1'b0;
        if (sb.errors == 0)
            $display("delta_kernel_interpolator: match");
        else
            $display("delta_kernel_interpolator: mismatch");
        $finish;
    end
endmodule

/* filelist.f */
sv/dki_pkg.sv
sv/dki_channels.sv
sv/dki_ctrl.sv
sv/dki_datapath.sv
sv/delta_kernel_interpolator.sv
sv/dki_checker.sv
verif/dki_tb_channels.sv
verif/testbench.sv
